[rtl/core/tccw_pkg.sv]
package tccw_pkg;

    // Control bytes
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;

    // Configuration register indexes
    localparam int          CFG_IDX_W   = 1;
    localparam int          CFG_DATA_W  = 8;
    localparam logic [0:0]  REG_COLUMNS = 1'b0;
    localparam logic [0:0]  REG_ROWS    = 1'b1;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Class of an incoming byte
    typedef enum logic [1:0] {
        C_PRINT = 2'd0,
        C_BS    = 2'd1,
        C_NL    = 2'd2
    } t_cls;

    // Kind of a result
    typedef enum logic [1:0] {
        K_STORE   = 2'd0,
        K_ERASE   = 2'd1,
        K_NEWLINE = 2'd2,
        K_IGNORE  = 2'd3
    } t_kind;

    // Classified request handed from front to back
    typedef struct packed {
        t_cls       cls;
        logic [7:0] ch;
    } t_op;

endpackage

[rtl/core/tccw_front.sv]
module tccw_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_hold,
    input  logic           i_in_valid,
    input  logic [7:0]     i_ch,
    output logic           o_in_ready,
    output logic           o_op_valid,
    output tccw_pkg::t_op  o_op,
    input  logic           i_op_ready
);
    import tccw_pkg::*;

    logic r_valid;
    t_op  r_op;
    t_op  n_op;
    logic accept;

    // Take a request when not held and the stage is empty or drains this cycle
    assign o_in_ready = !i_hold && (!r_valid || i_op_ready);
    assign accept     = i_in_valid && o_in_ready;

    // Classify the byte
    always_comb begin
        n_op.ch = i_ch;
        unique case (i_ch)
            CH_BACKSPACE: n_op.cls = C_BS;
            CH_NEWLINE:   n_op.cls = C_NL;
            default:      n_op.cls = C_PRINT;
        endcase
    end

    // Hold the classified request until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_op_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

    assign o_op_valid = r_valid;
    assign o_op       = r_op;

endmodule

[rtl/core/tccw_queue.sv]
module tccw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  tccw_pkg::t_op  i_push_op,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output tccw_pkg::t_op  o_pop_op,
    input  logic           i_pop_ready
);
    import tccw_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_op     = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store the pushed request
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_op;
        end
    end

endmodule

[rtl/core/tccw_back.sv]
module tccw_back #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64,
    parameter int CW       = 7,
    parameter int RW       = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [CW-1:0]  i_last_col,
    input  logic [RW-1:0]  i_last_row,
    input  logic           i_op_valid,
    input  tccw_pkg::t_op  i_op,
    output logic           o_op_ready,
    output logic           o_busy_clear,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_kind,
    output logic [6:0]     o_cell_col,
    output logic [5:0]     o_cell_row,
    output logic [7:0]     o_cell_char,
    output logic           o_scrolled,
    output logic [6:0]     o_cursor_col,
    output logic [5:0]     o_cursor_row
);
    import tccw_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_COPY  = 4'b0100,
        S_ZERO  = 4'b1000
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cur_col;
    logic [RW-1:0]   r_cur_row;
    logic [AW-1:0]   r_clr;
    logic [CW-1:0]   r_x;
    logic [RW-1:0]   r_y;
    logic [AW-1:0]   r_base;
    logic [CW-1:0]   r_sc_last_col;
    logic [RW-1:0]   r_sc_last_row;
    logic            r_cp_wr;
    logic [AW-1:0]   r_cp_wa;
    logic [7:0]      r_rd_data;
    logic [7:0]      r_mem [DEPTH];

    logic            r_out_valid;
    logic [1:0]      r_kind;
    logic [6:0]      r_cell_col;
    logic [5:0]      r_cell_row;
    logic [7:0]      r_cell_char;
    logic            r_scrolled;
    logic [6:0]      r_cursor_col;
    logic [5:0]      r_cursor_row;

    logic            pop;
    logic [CW-1:0]   cc;
    logic [RW-1:0]   cr;
    logic            do_nl;
    logic            scroll;
    logic            op_wr;
    logic [CW-1:0]   op_col;
    logic [7:0]      op_data;
    logic [AW-1:0]   op_addr;
    t_kind           kind;
    logic [CW-1:0]   cell_col;
    logic [RW-1:0]   cell_row;
    logic [7:0]      cell_char;
    logic [CW-1:0]   n_col;
    logic [RW-1:0]   n_row;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   sweep_addr;
    logic            copy_last_x;
    logic            zero_last_x;

    // Take a request only in idle and with room in the output register
    assign pop          = (r_state == S_IDLE) && i_op_valid && (!r_out_valid || i_out_ready);
    assign o_op_ready   = pop;
    assign o_busy_clear = (r_state == S_CLEAR);

    // Saturate the cursor to the grid in use
    assign cc = (r_cur_col > i_last_col) ? i_last_col : r_cur_col;
    assign cr = (r_cur_row > i_last_row) ? i_last_row : r_cur_row;

    // Work out the cell write, the result and the next cursor
    always_comb begin
        do_nl     = 1'b0;
        scroll    = 1'b0;
        op_wr     = 1'b0;
        op_col    = cc;
        op_data   = 8'd0;
        kind      = K_STORE;
        cell_col  = '0;
        cell_row  = '0;
        cell_char = 8'd0;
        n_col     = cc;
        n_row     = cr;
        unique case (i_op.cls)
            C_BS: begin
                if (cc != '0) begin
                    n_col    = cc - 1'b1;
                    op_wr    = 1'b1;
                    op_col   = cc - 1'b1;
                    kind     = K_ERASE;
                    cell_col = cc - 1'b1;
                    cell_row = cr;
                end else begin
                    kind = K_IGNORE;
                end
            end
            C_NL: begin
                kind  = K_NEWLINE;
                do_nl = 1'b1;
            end
            default: begin
                op_wr     = 1'b1;
                op_data   = i_op.ch;
                kind      = K_STORE;
                cell_col  = cc;
                cell_row  = cr;
                cell_char = i_op.ch;
                if (cc == i_last_col) begin
                    do_nl = 1'b1;
                end else begin
                    n_col = cc + 1'b1;
                end
            end
        endcase
        if (do_nl) begin
            n_col = '0;
            if (cr == i_last_row) begin
                scroll = 1'b1;
                n_row  = i_last_row;
            end else begin
                n_row = cr + 1'b1;
            end
        end
    end

    assign op_addr     = AW'(32'(cr) * MAX_COLS + 32'(op_col));
    assign sweep_addr  = AW'(32'(r_base) + 32'(r_x));
    assign rd_addr     = AW'(32'(r_base) + MAX_COLS + 32'(r_x));
    assign copy_last_x = (r_x == r_sc_last_col);
    assign zero_last_x = (r_x == r_sc_last_col);

    // Select the single memory write: pending copy first
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = op_addr;
        wr_data = op_data;
        if (r_cp_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_cp_wa;
            wr_data = r_rd_data;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    wr_en   = 1'b1;
                    wr_addr = r_clr;
                    wr_data = 8'd0;
                end
                S_ZERO: begin
                    wr_en   = 1'b1;
                    wr_addr = sweep_addr;
                    wr_data = 8'd0;
                end
                S_IDLE: begin
                    wr_en = pop && op_wr;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // Cell store: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (r_state == S_COPY) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Sequence clear, idle, row copy and bottom row zeroing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_cp_wr   <= 1'b0;
            r_x       <= '0;
            r_y       <= '0;
            r_base    <= '0;
        end else begin
            r_cp_wr <= (r_state == S_COPY);
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (pop) begin
                        r_cur_col <= n_col;
                        r_cur_row <= n_row;
                        r_x       <= '0;
                        r_y       <= '0;
                        r_base    <= '0;
                        if (scroll) begin
                            r_state <= (i_last_row == '0) ? S_ZERO : S_COPY;
                        end
                    end
                end
                S_COPY: begin
                    if (copy_last_x) begin
                        r_x    <= '0;
                        r_base <= AW'(32'(r_base) + MAX_COLS);
                        if (r_y == r_sc_last_row - 1'b1) begin
                            r_state <= S_ZERO;
                            r_y     <= '0;
                        end else begin
                            r_y <= r_y + 1'b1;
                        end
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                S_ZERO: begin
                    if (!r_cp_wr) begin
                        if (zero_last_x) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_x <= r_x + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Latch the scroll geometry and the copy write address
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_sc_last_col <= i_last_col;
            r_sc_last_row <= i_last_row;
        end
        r_cp_wa <= sweep_addr;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_kind       <= kind;
            r_cell_col   <= 7'(cell_col);
            r_cell_row   <= 6'(cell_row);
            r_cell_char  <= cell_char;
            r_scrolled   <= scroll;
            r_cursor_col <= 7'(n_col);
            r_cursor_row <= 6'(n_row);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_cell_col   = r_cell_col;
    assign o_cell_row   = r_cell_row;
    assign o_cell_char  = r_cell_char;
    assign o_scrolled   = r_scrolled;
    assign o_cursor_col = r_cursor_col;
    assign o_cursor_row = r_cursor_row;

    // A pending copy write never meets a new request
    a_no_pop_on_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_wr |-> !pop)
        else $error("request taken while a copy write is pending");

    // A scrolling request leaves idle on the next cycle
    a_scroll_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && scroll) |=> (r_state == S_COPY || r_state == S_ZERO))
        else $error("scroll did not start the row sweep");

    // A taken request always fills the output register
    a_pop_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_out_valid)
        else $error("request taken without a result");

    // No request is taken during the clearing pass
    a_no_pop_on_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_op_ready)
        else $error("request taken during clearing pass");

endmodule

[rtl/core/text_console_cell_writer.sv]
// Channel  Direction  Handshake                   Payload
// in       input      i_in_valid / o_in_ready     i_ch
// out      output     o_out_valid / i_out_ready   o_kind .. o_cursor_row
// cfg      input      i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
// An ordinary request passes the input stage, the queue and the output register in
// turn. A scroll stalls the back end while it copies each row up by one, drains the
// last copy write when rows > 1 and zeroes the bottom row; the single memory port
// sets this. After reset a pass zeroes all MAX_COLS*MAX_ROWS cells of the cell store
// with o_in_ready low. The two-entry queue lets the front keep accepting while the
// back stalls.
module text_console_cell_writer #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tccw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_ch,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_kind,
    output logic [6:0]                     o_cell_col,
    output logic [5:0]                     o_cell_row,
    output logic [7:0]                     o_cell_char,
    output logic                           o_scrolled,
    output logic [6:0]                     o_cursor_col,
    output logic [5:0]                     o_cursor_row
);
    import tccw_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [7:0]    r_columns;
    logic [6:0]    r_rows;
    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;
    logic          busy_clear;
    logic          f_valid;
    t_op           f_op;
    logic          f_ready;
    logic          q_valid;
    t_op           q_op;
    logic          q_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= 8'd80;
            r_rows    <= 7'd25;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COLUMNS: r_columns <= i_cfg_data[7:0];
                REG_ROWS:    r_rows    <= i_cfg_data[6:0];
                default:     ;
            endcase
        end
    end

    // Clamp the grid size to 1..maximum, kept as last index
    always_comb begin
        if (r_columns == 8'd0) begin
            last_col = '0;
        end else if (9'(r_columns) > 9'(MAX_COLS)) begin
            last_col = CW'(MAX_COLS - 1);
        end else begin
            last_col = CW'(r_columns - 8'd1);
        end
        if (r_rows == 7'd0) begin
            last_row = '0;
        end else if (8'(r_rows) > 8'(MAX_ROWS)) begin
            last_row = RW'(MAX_ROWS - 1);
        end else begin
            last_row = RW'(r_rows - 7'd1);
        end
    end

    tccw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (busy_clear),
        .i_in_valid (i_in_valid),
        .i_ch       (i_ch),
        .o_in_ready (o_in_ready),
        .o_op_valid (f_valid),
        .o_op       (f_op),
        .i_op_ready (f_ready)
    );

    tccw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_op    (f_op),
        .o_push_ready (f_ready),
        .o_pop_valid  (q_valid),
        .o_pop_op     (q_op),
        .i_pop_ready  (q_ready)
    );

    tccw_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CW       (CW),
        .RW       (RW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_last_col   (last_col),
        .i_last_row   (last_row),
        .i_op_valid   (q_valid),
        .i_op         (q_op),
        .o_op_ready   (q_ready),
        .o_busy_clear (busy_clear),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_cell_col   (o_cell_col),
        .o_cell_row   (o_cell_row),
        .o_cell_char  (o_cell_char),
        .o_scrolled   (o_scrolled),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row)
    );

endmodule

[bench/tb_text_console_cell_writer.sv]
module tb_text_console_cell_writer;
    import tccw_pkg::*;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 64;
    localparam int LONG_LINES = 66;
    localparam int MIXED_PHASES = 10;
    localparam int PHASE_ITEMS = 100;

    // One drawing update reported by the console
    typedef struct packed {
        t_kind      kind;
        logic [6:0] cell_col;
        logic [5:0] cell_row;
        logic [7:0] cell_char;
        logic       scrolled;
        logic [6:0] cursor_col;
        logic [5:0] cursor_row;
    } cell_update_t;

    // One step of the opening script: a register write or a character
    typedef struct packed {
        logic         is_cfg;
        logic [0:0]   reg_idx;
        logic [7:0]   data;
        logic         known;
        cell_update_t want;
    } script_line_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_ch = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [1:0]            o_kind;
    logic [6:0]            o_cell_col;
    logic [5:0]            o_cell_row;
    logic [7:0]            o_cell_char;
    logic                  o_scrolled;
    logic [6:0]            o_cursor_col;
    logic [5:0]            o_cursor_row;

    // Predicted cursor and grid size; cell contents never reach the outputs
    logic [6:0] cursor_x = '0;
    logic [5:0] cursor_y = '0;
    logic [7:0] columns_reg = 8'd80;
    logic [6:0] rows_reg = 7'd25;

    cell_update_t updates_due[$];
    script_line_t script[$];
    int           mismatch_count = 0;
    bit           steady = 1'b0;

    text_console_cell_writer #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_ch(i_ch),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_kind(o_kind),
        .o_cell_col(o_cell_col),
        .o_cell_row(o_cell_row),
        .o_cell_char(o_cell_char),
        .o_scrolled(o_scrolled),
        .o_cursor_col(o_cursor_col),
        .o_cursor_row(o_cursor_row)
    );

    always #10 i_clk = ~i_clk;

    // Bound a register value to the range the grid supports
    function automatic int clamp_size(input int value, input int top);
        if (value == 0) return 1;
        if (value > top) return top;
        return value;
    endfunction

    // Apply one character to the predicted cursor and return the update
    function automatic cell_update_t advance_cursor(input logic [7:0] ch);
        cell_update_t upd;
        int           nc;
        int           nr;
        int           x;
        int           y;
        logic         go_down;
        nc = clamp_size(int'(columns_reg), MAX_COLS);
        nr = clamp_size(int'(rows_reg), MAX_ROWS);
        x = int'(cursor_x);
        y = int'(cursor_y);
        upd = '0;
        go_down = 1'b0;
        // pull the cursor back inside a grid that shrank
        if (x >= nc) x = nc - 1;
        if (y >= nr) y = nr - 1;
        if (ch == CH_BACKSPACE) begin
            if (x > 0) begin
                x = x - 1;
                upd.kind = K_ERASE;
                upd.cell_col = 7'(x);
                upd.cell_row = 6'(y);
            end else begin
                upd.kind = K_IGNORE;
            end
        end else if (ch == CH_NEWLINE) begin
            upd.kind = K_NEWLINE;
            go_down = 1'b1;
        end else begin
            upd.kind = K_STORE;
            upd.cell_col = 7'(x);
            upd.cell_row = 6'(y);
            upd.cell_char = ch;
            x = x + 1;
            if (x >= nc) go_down = 1'b1;
        end
        // new line: step down, or scroll on the bottom row
        if (go_down) begin
            x = 0;
            if (y + 1 >= nr) upd.scrolled = 1'b1;
            else y = y + 1;
        end
        cursor_x = 7'(x);
        cursor_y = 6'(y);
        upd.cursor_col = cursor_x;
        upd.cursor_row = cursor_y;
        return upd;
    endfunction

    function automatic logic [7:0] random_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12) return CH_BACKSPACE;
        if (roll < 25) return CH_NEWLINE;
        if (roll < 40) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void put_cfg(input logic [0:0] idx, input logic [7:0] value);
        script_line_t line;
        line = '0;
        line.is_cfg = 1'b1;
        line.reg_idx = idx;
        line.data = value;
        script.push_back(line);
    endfunction

    function automatic void put_char(input logic [7:0] ch);
        script_line_t line;
        line = '0;
        line.data = ch;
        script.push_back(line);
    endfunction

    function automatic void put_known(input logic [7:0] ch, input t_kind kind,
                                      input int ccol, input int crow, input logic [7:0] cchar,
                                      input logic scr, input int xcol, input int xrow);
        script_line_t line;
        line = '0;
        line.data = ch;
        line.known = 1'b1;
        line.want.kind = kind;
        line.want.cell_col = 7'(ccol);
        line.want.cell_row = 6'(crow);
        line.want.cell_char = cchar;
        line.want.scrolled = scr;
        line.want.cursor_col = 7'(xcol);
        line.want.cursor_row = 6'(xrow);
        script.push_back(line);
    endfunction

    // Present one character request and hold it until taken
    task automatic send_char(input logic [7:0] ch, input logic known, input cell_update_t want);
        cell_update_t predicted;
        if (!steady && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch <= ch;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = advance_cursor(ch);
        updates_due.push_back(known ? want : predicted);
    endtask

    // Drop valid and wait for every outstanding update
    task automatic settle();
        i_in_valid <= 1'b0;
        while (updates_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_COLUMNS) columns_reg = value;
        else rows_reg = value[6:0];
        @(posedge i_clk);
    endtask

    // Stall the result side at random, except in the steady phase
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 15);
    end

    // Compare each accepted update with the oldest prediction
    always @(posedge i_clk) begin
        cell_update_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (updates_due.size() == 0) begin
                $display("%0t: unexpected update, expected none, actual kind %0d col %0d row %0d",
                         $time, o_kind, o_cell_col, o_cell_row);
                mismatch_count++;
            end else begin
                want = updates_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("cell_col", 32'(want.cell_col), 32'(o_cell_col));
                check_field("cell_row", 32'(want.cell_row), 32'(o_cell_row));
                check_field("cell_char", 32'(want.cell_char), 32'(o_cell_char));
                check_field("scrolled", 32'(want.scrolled), 32'(o_scrolled));
                check_field("cursor_col", 32'(want.cursor_col), 32'(o_cursor_col));
                check_field("cursor_row", 32'(want.cursor_row), 32'(o_cursor_row));
            end
        end
    end

    initial begin
        script_line_t line;
        logic [7:0]   ch;
        logic [7:0]   cols_val;
        logic [7:0]   rows_val;
        int           len;

        // default 80x25 grid: edge bytes, erase, ignored backspace, newlines
        put_known(CH_BACKSPACE, K_IGNORE, 0, 0, 8'h00, 1'b0, 0, 0);
        put_known(8'h41, K_STORE, 0, 0, 8'h41, 1'b0, 1, 0);
        put_known(CH_BACKSPACE, K_ERASE, 0, 0, 8'h00, 1'b0, 0, 0);
        put_known(8'h00, K_STORE, 0, 0, 8'h00, 1'b0, 1, 0);
        put_known(8'hFF, K_STORE, 1, 0, 8'hFF, 1'b0, 2, 0);
        put_known(CH_NEWLINE, K_NEWLINE, 0, 0, 8'h00, 1'b0, 0, 1);
        put_known(CH_NEWLINE, K_NEWLINE, 0, 0, 8'h00, 1'b0, 0, 2);
        put_char(8'h20);
        put_char(8'h09);
        put_char(8'h7F);
        // shrink to 2x2: cursor at (3,2) is pulled back to (1,1)
        put_cfg(REG_COLUMNS, 8'h02);
        put_cfg(REG_ROWS, 8'h02);
        put_known(8'h61, K_STORE, 1, 1, 8'h61, 1'b1, 0, 1);
        put_known(CH_BACKSPACE, K_IGNORE, 0, 0, 8'h00, 1'b0, 0, 1);
        put_known(8'h62, K_STORE, 0, 1, 8'h62, 1'b0, 1, 1);
        put_known(CH_BACKSPACE, K_ERASE, 0, 1, 8'h00, 1'b0, 0, 1);
        put_known(CH_NEWLINE, K_NEWLINE, 0, 0, 8'h00, 1'b1, 0, 1);
        // zero sizes act as a 1x1 grid; high bit of rows is dropped
        put_cfg(REG_COLUMNS, 8'h00);
        put_cfg(REG_ROWS, 8'h80);
        put_known(8'h78, K_STORE, 0, 0, 8'h78, 1'b1, 0, 0);
        put_known(CH_NEWLINE, K_NEWLINE, 0, 0, 8'h00, 1'b1, 0, 0);
        put_known(CH_BACKSPACE, K_IGNORE, 0, 0, 8'h00, 1'b0, 0, 0);
        // oversize values saturate to the full grid
        put_cfg(REG_COLUMNS, 8'hFF);
        put_cfg(REG_ROWS, 8'hFF);
        put_known(8'hAA, K_STORE, 0, 0, 8'hAA, 1'b0, 1, 0);
        put_known(CH_NEWLINE, K_NEWLINE, 0, 0, 8'h00, 1'b0, 0, 1);
        put_cfg(REG_COLUMNS, 8'h80);
        put_cfg(REG_ROWS, 8'h40);
        put_known(8'h55, K_STORE, 0, 1, 8'h55, 1'b0, 1, 1);
        put_known(CH_BACKSPACE, K_ERASE, 0, 1, 8'h00, 1'b0, 0, 1);

        // hold reset, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the opening script
        foreach (script[i]) begin
            line = script[i];
            if (line.is_cfg) begin
                settle();
                write_reg(line.reg_idx, line.data);
            end else begin
                send_char(line.data, line.known, line.want);
            end
        end

        // full grid: lines of text that reach the bottom row and scroll
        settle();
        write_reg(REG_COLUMNS, 8'd128);
        write_reg(REG_ROWS, 8'd64);
        for (int n = 0; n < LONG_LINES; n++) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 135)
                                               : $urandom_range(0, 3);
            for (int k = 0; k < len; k++) begin
                ch = random_char();
                if (ch == CH_NEWLINE) ch = 8'h2E;
                send_char(ch, 1'b0, '0);
            end
            send_char(CH_NEWLINE, 1'b0, '0);
        end

        // mixed traffic over random, mostly small grids
        for (int p = 0; p < MIXED_PHASES; p++) begin
            settle();
            do begin
                case ($urandom_range(0, 9))
                    0: cols_val = 8'h00;
                    1: cols_val = 8'($urandom_range(129, 255));
                    2: cols_val = 8'($urandom_range(17, 128));
                    default: cols_val = 8'($urandom_range(1, 16));
                endcase
                rows_val = {1'($urandom_range(0, 1)),
                            7'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(0, 8))};
            end while (clamp_size(int'(cols_val), MAX_COLS) *
                       clamp_size(int'(rows_val[6:0]), MAX_ROWS) > 600);
            write_reg(REG_COLUMNS, cols_val);
            write_reg(REG_ROWS, rows_val);
            steady = (p == 3);
            repeat (PHASE_ITEMS) send_char(random_char(), 1'b0, '0);
        end
        steady = 1'b0;

        // drain and give stray updates a chance to show
        settle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && updates_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #80_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
